/* hw/rtl/klr_pkg.sv */
// shared types, codes and the binomial builder for the k-subset rank/unrank block
package klr_pkg;

	localparam int DEF_MAX_N = 32;
	localparam int DEF_MAX_K = 16;
	localparam int PASCAL_N  = 64;

	localparam int BINOM_W = 31;
	localparam logic [BINOM_W-1:0] BINOM_SAT = 31'h4000_0000;

	localparam int ADDR_W = 5;
	localparam int CNT_W  = 6;
	localparam int NW     = 7;

	localparam logic [2:0] OP_FIRST  = 3'd0;
	localparam logic [2:0] OP_SUCC   = 3'd1;
	localparam logic [2:0] OP_RANK   = 3'd2;
	localparam logic [2:0] OP_UNRANK = 3'd3;
	localparam logic [2:0] OP_WRITE  = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;

	localparam logic CFG_SET_SIZE    = 1'b0;
	localparam logic CFG_SUBSET_SIZE = 1'b1;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  index;
		logic [4:0]  value;
		logic [29:0] rank_in;
	} cmd_t;

	typedef struct packed {
		logic [29:0] rank_out;
		logic [4:0]  element;
		logic        has_next;
		logic [1:0]  status;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUCC_RD,
		S_SUCC_CMP,
		S_SUCC_WR,
		S_RANK_RD,
		S_RANK_ELEM,
		S_RANK_J,
		S_RANK_ADD,
		S_TOT_RD,
		S_TOT_CHK,
		S_UNR_T,
		S_UNR_CHK,
		S_READ_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [4:0]        wdata;
		logic              clr;
		logic [CNT_W-1:0]  clr_cnt;
	} store_req_t;

	typedef struct packed {
		logic          re;
		logic          zero;
		logic [NW-1:0] a;
		logic [5:0]    b;
	} rom_req_t;

	// pascal triangle with saturation at 2^30
	function automatic logic [BINOM_W-1:0] binom_sat(input int a, input int b);
		logic [BINOM_W-1:0] row [0:PASCAL_N];
		logic [BINOM_W:0]   s;
		int r;
		int c;
		for (c = 0; c <= PASCAL_N; c++)
			row[c] = '0;
		row[0] = 31'd1;
		if (a < 0 || b < 0 || b > a || a > PASCAL_N)
			return '0;
		for (r = 1; r <= a; r++) begin
			for (c = (r < b) ? r : b; c >= 1; c--) begin
				s = {1'b0, row[c]} + {1'b0, row[c-1]};
				row[c] = (s > {1'b0, BINOM_SAT}) ? BINOM_SAT : s[BINOM_W-1:0];
			end
		end
		return row[b];
	endfunction

endpackage

/* hw/rtl/klr_store.sv */
// subset element memory with per-entry valid bits and registered read
module klr_store #(
	parameter int MAX_K = klr_pkg::DEF_MAX_K
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  klr_pkg::store_req_t  req,
	output logic [4:0]           rdata
);
	import klr_pkg::*;

	localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

	logic [4:0]       mem [MAX_K];
	logic [MAX_K-1:0] valid_q;
	logic [IW-1:0]    ra;
	logic [IW-1:0]    wa;
	logic [4:0]       mem_s1;
	logic             vld_s1;
	logic             fwd_s1;
	logic [4:0]       wdata_s1;
	logic [IW-1:0]    addr_s1;

	assign ra = req.raddr[IW-1:0];
	assign wa = req.waddr[IW-1:0];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[wa] <= req.wdata;
		end
		if (req.re) begin
			mem_s1   <= mem[ra];
			vld_s1   <= valid_q[ra];
			fwd_s1   <= req.we && (wa == ra);
			wdata_s1 <= req.wdata;
			addr_s1  <= ra;
		end
	end

	// invalid entry reads as its own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (req.clr) begin
				for (int e = 0; e < MAX_K; e++) begin
					if (CNT_W'(e) < req.clr_cnt)
						valid_q[e] <= 1'b0;
				end
			end
			if (req.we) begin
				valid_q[wa] <= 1'b1;
			end
		end
	end

	assign rdata = fwd_s1 ? wdata_s1 : (vld_s1 ? mem_s1 : 5'(addr_s1));

endmodule

/* hw/rtl/klr_binom_rom.sv */
// binomial coefficient table with registered read
module klr_binom_rom #(
	parameter int MAX_N = klr_pkg::DEF_MAX_N,
	parameter int MAX_K = klr_pkg::DEF_MAX_K
) (
	input  logic                          clk,
	input  klr_pkg::rom_req_t             req,
	output logic [klr_pkg::BINOM_W-1:0]   data
);
	import klr_pkg::*;

	localparam int AW = $clog2(MAX_N + 1);
	localparam int BW = $clog2(MAX_K + 1);

	logic [BINOM_W-1:0] tbl [MAX_N+1][MAX_K+1];

	for (genvar ga = 0; ga <= MAX_N; ga++) begin : g_row
		for (genvar gb = 0; gb <= MAX_K; gb++) begin : g_col
			assign tbl[ga][gb] = binom_sat(ga, gb);
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			data <= req.zero ? '0 : tbl[req.a[AW-1:0]][req.b[BW-1:0]];
		end
	end

endmodule

/* hw/rtl/klr_seq.sv */
// operation sequencer: config registers, control fsm and rank datapath
module klr_seq #(
	parameter int MAX_N = klr_pkg::DEF_MAX_N,
	parameter int MAX_K = klr_pkg::DEF_MAX_K
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  klr_pkg::cmd_t                 cmd,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [5:0]                    cfg_data,
	output logic                          fin,
	input  logic                          take,
	output klr_pkg::res_t                 res,
	output klr_pkg::store_req_t           store_req,
	input  logic [4:0]                    store_rdata,
	output klr_pkg::rom_req_t             rom_req,
	input  logic [klr_pkg::BINOM_W-1:0]   rom_data
);
	import klr_pkg::*;

	state_t             state_q;
	state_t             state_d;
	cmd_t               cmd_q;
	res_t               res_q;
	logic [5:0]         n_q;
	logic [4:0]         k_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic [CNT_W-1:0]   prev_q;
	logic [CNT_W-1:0]   cur_q;
	logic [7:0]         x_q;
	logic [29:0]        left_q;
	logic [BINOM_W-1:0] acc_q;
	logic [4:0]         base_q;

	logic               accept;
	logic               cfg_ok;
	logic               idx_ok;
	logic               val_ok;
	logic [NW-1:0]      lim;
	logic               at_lim;
	logic [BINOM_W:0]   sum;
	logic               step_ok;
	logic               i_last;
	logic [CNT_W-1:0]   k_ext;
	logic [1:0]         acc_status;

	assign k_ext   = {1'b0, k_q};
	assign accept  = cmd_valid && (state_q == S_IDLE);
	assign cfg_ok  = (n_q != 6'd0) && ({1'b0, n_q} <= NW'(MAX_N)) &&
		(k_ext <= CNT_W'(MAX_K)) && ({1'b0, k_q} <= n_q);
	assign idx_ok  = {1'b0, cmd.index} < k_q;
	assign val_ok  = {1'b0, cmd.value} < n_q;
	assign lim     = {1'b0, n_q} - {2'b0, k_q} + {1'b0, i_q};
	assign at_lim  = {2'b0, store_rdata} == lim;
	assign sum     = {1'b0, acc_q} + {1'b0, rom_data};
	assign step_ok = (rom_data <= {1'b0, left_q}) && (x_q <= {2'b0, n_q});
	assign i_last  = (i_q == k_ext);
	assign cfg_ready = 1'b1;

	// status known at accept
	assign acc_status = (cmd.op > OP_READ) ? ST_OK :
		(!cfg_ok || (cmd.op == OP_WRITE && !(idx_ok && val_ok)) ||
		(cmd.op == OP_READ && !idx_ok)) ? ST_BAD : ST_OK;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 6'd8;
			k_q <= 5'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SET_SIZE:    n_q <= cfg_data;
				CFG_SUBSET_SIZE: k_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op > OP_READ || !cfg_ok) begin
						state_d = S_DONE;
					end else begin
						unique case (cmd.op)
							OP_SUCC:   state_d = (k_q == 5'd0) ? S_DONE : S_SUCC_RD;
							OP_RANK:   state_d = (k_q == 5'd0) ? S_TOT_RD : S_RANK_RD;
							OP_UNRANK: state_d = S_TOT_RD;
							OP_READ:   state_d = idx_ok ? S_READ_WAIT : S_DONE;
							default:   state_d = S_DONE;
						endcase
					end
				end
			end
			S_SUCC_RD:  state_d = S_SUCC_CMP;
			S_SUCC_CMP: begin
				if (!at_lim)
					state_d = S_SUCC_WR;
				else if (i_q == '0)
					state_d = S_DONE;
				else
					state_d = S_SUCC_RD;
			end
			S_SUCC_WR:   state_d = (j_q == k_ext - 1'b1) ? S_DONE : S_SUCC_WR;
			S_RANK_RD:   state_d = S_RANK_ELEM;
			S_RANK_ELEM: state_d = S_RANK_J;
			S_RANK_J: begin
				if (j_q < cur_q)
					state_d = S_RANK_ADD;
				else if (i_last)
					state_d = S_TOT_RD;
				else
					state_d = S_RANK_RD;
			end
			S_RANK_ADD: state_d = S_RANK_J;
			S_TOT_RD:   state_d = S_TOT_CHK;
			S_TOT_CHK: begin
				if (cmd_q.op == OP_RANK || {1'b0, left_q} >= rom_data || k_q == 5'd0)
					state_d = S_DONE;
				else
					state_d = S_UNR_T;
			end
			S_UNR_T:   state_d = S_UNR_CHK;
			S_UNR_CHK: state_d = (!step_ok && i_last) ? S_DONE : S_UNR_T;
			S_READ_WAIT: state_d = S_DONE;
			S_DONE:    state_d = take ? S_IDLE : S_DONE;
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_stall = (state_q != S_IDLE);
		fin       = (state_q == S_DONE);
		res       = res_q;
		store_req = '0;
		rom_req   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd.op <= OP_READ && cfg_ok) begin
					store_req.re    = (cmd.op == OP_READ);
					store_req.raddr = ADDR_W'(cmd.index);
					store_req.we    = (cmd.op == OP_WRITE) && idx_ok && val_ok;
					store_req.waddr = ADDR_W'(cmd.index);
					store_req.wdata = cmd.value;
					store_req.clr   = (cmd.op == OP_FIRST);
					store_req.clr_cnt = k_ext;
				end
			end
			S_SUCC_RD: begin
				store_req.re    = 1'b1;
				store_req.raddr = ADDR_W'(i_q);
			end
			S_SUCC_WR: begin
				store_req.we    = 1'b1;
				store_req.waddr = ADDR_W'(j_q);
				store_req.wdata = base_q;
			end
			S_RANK_RD: begin
				store_req.re    = 1'b1;
				store_req.raddr = ADDR_W'(i_q - 1'b1);
			end
			S_RANK_J: begin
				rom_req.re   = 1'b1;
				rom_req.zero = ({1'b0, j_q} > {1'b0, n_q});
				rom_req.a    = NW'({1'b0, n_q} - j_q);
				rom_req.b    = k_ext - i_q;
			end
			S_TOT_RD: begin
				rom_req.re = 1'b1;
				rom_req.a  = {1'b0, n_q};
				rom_req.b  = k_ext;
			end
			S_UNR_T: begin
				rom_req.re   = 1'b1;
				rom_req.zero = (x_q > {2'b0, n_q});
				rom_req.a    = NW'({2'b0, n_q} - x_q);
				rom_req.b    = k_ext - i_q;
			end
			S_UNR_CHK: begin
				store_req.we    = !step_ok;
				store_req.waddr = ADDR_W'(i_q - 1'b1);
				store_req.wdata = 5'(x_q - 1'b1);
			end
			default: ;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q  <= cmd;
					res_q  <= '{rank_out: '0, element: '0, has_next: 1'b0,
						status: acc_status};
					acc_q  <= '0;
					prev_q <= '0;
					x_q    <= 8'd1;
					left_q <= cmd.rank_in;
					i_q    <= (cmd.op == OP_SUCC) ? k_ext - 1'b1 : CNT_W'(1);
				end
			end
			S_SUCC_CMP: begin
				if (!at_lim) begin
					base_q <= store_rdata + 5'd1;
					j_q    <= i_q;
				end else if (i_q != '0) begin
					i_q <= i_q - 1'b1;
				end
			end
			S_SUCC_WR: begin
				j_q    <= j_q + 1'b1;
				base_q <= base_q + 5'd1;
				if (j_q == k_ext - 1'b1)
					res_q.has_next <= 1'b1;
			end
			S_RANK_ELEM: begin
				cur_q <= {1'b0, store_rdata} + 1'b1;
				j_q   <= prev_q + 1'b1;
			end
			S_RANK_J: begin
				if (!(j_q < cur_q)) begin
					prev_q <= cur_q;
					if (!i_last)
						i_q <= i_q + 1'b1;
				end
			end
			S_RANK_ADD: begin
				acc_q <= (sum > {1'b0, BINOM_SAT}) ? BINOM_SAT : sum[BINOM_W-1:0];
				j_q   <= j_q + 1'b1;
			end
			S_TOT_CHK: begin
				if (cmd_q.op == OP_RANK) begin
					if (acc_q >= rom_data)
						res_q.status <= ST_RANGE;
					else
						res_q.rank_out <= acc_q[29:0];
				end else if ({1'b0, left_q} >= rom_data) begin
					res_q.status <= ST_RANGE;
				end
			end
			S_UNR_CHK: begin
				x_q <= x_q + 8'd1;
				if (step_ok)
					left_q <= left_q - rom_data[29:0];
				else if (!i_last)
					i_q <= i_q + 1'b1;
			end
			S_READ_WAIT: begin
				res_q.element <= store_rdata;
			end
			default: ;
		endcase
	end

endmodule

/* hw/rtl/k_subset_lex_rank_unrank.sv */
// k-subset store with first, successor, rank, unrank, write and read
// first, write, unknown op or error go straight to the result; read waits for the store read
// successor: scans positions from the last, then rewrites each element from there to the end
// rank: reads each element and adds its binomial terms in turn, then checks the total
// unrank: checks the total, then at most n+k binomial table reads; one item at a time
// reset: n=8, k=3, every store entry reads its own index through cleared valid bits
module k_subset_lex_rank_unrank #(
	parameter int MAX_N = klr_pkg::DEF_MAX_N,
	parameter int MAX_K = klr_pkg::DEF_MAX_K
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  klr_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output klr_pkg::res_t  res,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_index,
	input  logic [5:0]     cfg_data
);
	import klr_pkg::*;

	store_req_t         store_req;
	rom_req_t           rom_req;
	logic [4:0]         store_rdata;
	logic [BINOM_W-1:0] rom_data;
	logic               fin;
	logic               take;
	res_t               seq_res;
	logic               res_valid_q;
	res_t               res_q;

	klr_seq #(
		.MAX_N(MAX_N),
		.MAX_K(MAX_K)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fin        (fin),
		.take       (take),
		.res        (seq_res),
		.store_req  (store_req),
		.store_rdata(store_rdata),
		.rom_req    (rom_req),
		.rom_data   (rom_data)
	);

	klr_store #(
		.MAX_K(MAX_K)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (store_req),
		.rdata (store_rdata)
	);

	klr_binom_rom #(
		.MAX_N(MAX_N),
		.MAX_K(MAX_K)
	) u_rom (
		.clk (clk),
		.req (rom_req),
		.data(rom_data)
	);

	// output register frees the sequencer for the next transfer
	assign take = fin && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= seq_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* test/tb_k_subset_lex_rank_unrank.sv */
// testbench for the k-subset lexicographic rank/unrank block with a self-checking scoreboard
`timescale 1ns / 1ps

module tb_k_subset_lex_rank_unrank;
	import klr_pkg::*;

	localparam int LIMIT_CYCLES = 5_000_000;
	localparam int SETTLE_CYCLES = 200;

	class subset_scoreboard;
		logic [5:0] n_reg;
		logic [4:0] k_reg;
		logic [4:0] elems [DEF_MAX_K];
		res_t pending [$];
		int errors;
		int checked;

		function new();
			n_reg = 6'd8;
			k_reg = 5'd3;
			for (int i = 0; i < DEF_MAX_K; i++)
				elems[i] = i[4:0];
			errors = 0;
			checked = 0;
		endfunction

		function longint unsigned choose(int a, int b);
			longint unsigned row [0:DEF_MAX_N];
			if (a < 0 || b < 0 || b > a || a > DEF_MAX_N)
				return 0;
			for (int c = 0; c <= DEF_MAX_N; c++)
				row[c] = 0;
			row[0] = 1;
			for (int r = 1; r <= a; r++)
				for (int c = (r < b) ? r : b; c >= 1; c--)
					row[c] += row[c-1];
			return row[b];
		endfunction

		function void write_reg(logic idx, logic [5:0] data);
			if (idx == CFG_SET_SIZE)
				n_reg = data;
			else
				k_reg = data[4:0];
		endfunction

		function bit cfg_valid_now();
			return n_reg >= 1 && n_reg <= DEF_MAX_N && k_reg <= DEF_MAX_K && k_reg <= n_reg;
		endfunction

		function longint unsigned subset_count();
			return choose(int'(n_reg), int'(k_reg));
		endfunction

		function void note_cmd(cmd_t c);
			res_t r;
			int n;
			int k;
			int prev;
			int cur;
			int x;
			longint unsigned acc;
			longint unsigned left;
			longint unsigned t;
			logic [4:0] base;
			logic [4:0] tmp [DEF_MAX_K];
			r = '0;
			n = int'(n_reg);
			k = int'(k_reg);
			if (c.op > OP_READ) begin
				pending.push_back(r);
				return;
			end
			if (!cfg_valid_now()) begin
				r.status = ST_BAD;
				pending.push_back(r);
				return;
			end
			case (c.op)
				OP_FIRST: begin
					for (int i = 0; i < k; i++)
						elems[i] = i[4:0];
				end
				OP_SUCC: begin
					for (int i = k - 1; i >= 0; i--) begin
						if (int'(elems[i]) != n - k + i) begin
							base = elems[i] + 5'd1;
							elems[i] = base;
							for (int j = i + 1; j < k; j++)
								elems[j] = base + 5'(j - i);
							r.has_next = 1'b1;
							break;
						end
					end
				end
				OP_RANK: begin
					acc = 0;
					prev = 0;
					for (int i = 1; i <= k; i++) begin
						cur = int'(elems[i-1]) + 1;
						for (int j = prev + 1; j <= cur - 1; j++)
							acc += choose(n - j, k - i);
						prev = cur;
					end
					if (acc >= choose(n, k))
						r.status = ST_RANGE;
					else
						r.rank_out = acc[29:0];
				end
				OP_UNRANK: begin
					if (longint'(c.rank_in) >= choose(n, k)) begin
						r.status = ST_RANGE;
					end else begin
						left = c.rank_in;
						x = 1;
						for (int i = 1; i <= k; i++) begin
							t = choose(n - x, k - i);
							while (t <= left && x <= n) begin
								left -= t;
								x++;
								t = choose(n - x, k - i);
							end
							tmp[i-1] = 5'(x - 1);
							x++;
						end
						for (int i = 0; i < k; i++)
							elems[i] = tmp[i];
					end
				end
				OP_WRITE: begin
					if (int'(c.index) >= k || int'(c.value) >= n)
						r.status = ST_BAD;
					else
						elems[c.index] = c.value;
				end
				default: begin
					if (int'(c.index) >= k)
						r.status = ST_BAD;
					else
						r.element = elems[c.index];
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check_res(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.rank_out !== want.rank_out) begin
				$display("%0t: rank_out expected %0d actual %0d", $time, want.rank_out,
					got.rank_out);
				errors++;
			end
			if (got.element !== want.element) begin
				$display("%0t: element expected %0d actual %0d", $time, want.element,
					got.element);
				errors++;
			end
			if (got.has_next !== want.has_next) begin
				$display("%0t: has_next expected %0d actual %0d", $time, want.has_next,
					got.has_next);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status,
					got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [5:0] cfg_data;

	subset_scoreboard sb;
	int cycles = 0;
	int sent;
	bit calm;

	k_subset_lex_rank_unrank dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stall before each transfer, none while calm
	initial begin
		int hold;
		res_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				@(negedge clk);
				res_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	always @(posedge clk)
		if (arst_n && res_valid && !res_stall)
			sb.check_res(res);

	task automatic send_cmd(input logic [2:0] op, input logic [3:0] idx, input logic [4:0] val,
		input logic [29:0] rnk);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd <= '{op: op, index: idx, value: val, rank_in: rnk};
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sb.note_cmd(cmd);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [5:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_shape(input logic [5:0] n, input logic [5:0] k);
		drain();
		write_cfg(CFG_SET_SIZE, n);
		write_cfg(CFG_SUBSET_SIZE, k);
	endtask

	task automatic random_items(input int count);
		int pick;
		logic [2:0] op;
		logic [3:0] idx;
		logic [4:0] val;
		logic [29:0] rnk;
		longint unsigned total;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) op = OP_FIRST;
			else if (pick < 35) op = OP_SUCC;
			else if (pick < 55) op = OP_RANK;
			else if (pick < 75) op = OP_UNRANK;
			else if (pick < 85) op = OP_WRITE;
			else if (pick < 96) op = OP_READ;
			else op = 3'($urandom_range(6, 7));
			if (sb.k_reg > 0 && sb.k_reg <= DEF_MAX_K && $urandom_range(0, 9) < 8)
				idx = 4'($urandom_range(0, sb.k_reg - 1));
			else
				idx = 4'($urandom);
			if (sb.n_reg > 0 && sb.n_reg <= DEF_MAX_N && $urandom_range(0, 9) < 8)
				val = 5'($urandom_range(0, sb.n_reg - 1));
			else
				val = 5'($urandom);
			total = sb.subset_count();
			if (total > 0 && $urandom_range(0, 9) < 8)
				rnk = 30'($urandom_range(0, 32'(total - 1)));
			else
				rnk = 30'($urandom);
			send_cmd(op, idx, val, rnk);
		end
	endtask

	initial begin
		sb = new();
		sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SET_SIZE;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset shape n=8 k=3
		send_cmd(OP_READ, 4'd0, 5'd0, 30'd0);
		send_cmd(OP_READ, 4'd2, 5'd0, 30'd0);
		send_cmd(OP_READ, 4'd15, 5'd0, 30'd0);
		send_cmd(OP_RANK, 4'd0, 5'd0, 30'd0);
		send_cmd(OP_SUCC, 4'd0, 5'd0, 30'd0);
		send_cmd(OP_UNRANK, 4'd0, 5'd0, 30'd55);
		send_cmd(OP_SUCC, 4'd0, 5'd0, 30'd0);
		send_cmd(OP_UNRANK, 4'd0, 5'd0, 30'd56);
		send_cmd(OP_UNRANK, 4'd0, 5'd0, 30'h3FFF_FFFF);
		send_cmd(OP_WRITE, 4'd0, 5'd7, 30'd0);
		send_cmd(OP_WRITE, 4'd1, 5'd31, 30'd0);
		send_cmd(OP_RANK, 4'd0, 5'd0, 30'd0);
		send_cmd(OP_SUCC, 4'd0, 5'd0, 30'd0);
		send_cmd(OP_FIRST, 4'd0, 5'd0, 30'd0);
		send_cmd(3'd6, 4'hF, 5'h1F, 30'h3FFF_FFFF);
		send_cmd(3'd7, 4'd0, 5'd0, 30'd0);
		set_shape(6'd32, 6'd16);
		send_cmd(OP_UNRANK, 4'd0, 5'd0, 30'd601080389);
		send_cmd(OP_RANK, 4'd0, 5'd0, 30'd0);
		send_cmd(OP_SUCC, 4'd0, 5'd0, 30'd0);
		send_cmd(OP_READ, 4'd15, 5'd0, 30'd0);
		set_shape(6'd1, 6'd0);
		send_cmd(OP_SUCC, 4'd0, 5'd0, 30'd0);
		send_cmd(OP_RANK, 4'd0, 5'd0, 30'd0);
		send_cmd(OP_UNRANK, 4'd0, 5'd0, 30'd1);
		send_cmd(OP_READ, 4'd0, 5'd0, 30'd0);

		random_items(30);
		set_shape(6'd32, 6'd16);
		random_items(250);
		set_shape(6'd8, 6'd3);
		calm = 1'b1;
		random_items(100);
		calm = 1'b0;
		random_items(100);
		set_shape(6'd1, 6'd1);
		random_items(40);
		set_shape(6'd32, 6'd1);
		random_items(80);
		set_shape(6'd12, 6'd12);
		random_items(80);
		set_shape(6'd20, 6'd10);
		random_items(200);
		set_shape(6'd5, 6'd7);
		random_items(30);
		set_shape(6'd63, 6'd31);
		random_items(30);
		set_shape(6'd0, 6'd0);
		random_items(20);
		set_shape(6'd32, 6'd20);
		random_items(20);
		set_shape(6'd16, 6'd4);
		random_items(250);

		drain();
		$display("%0d commands sent over 13 shapes, %0d results checked, %0d mismatches",
			sent, sb.checked, sb.errors);
		$display("shapes covered n from 0 to 63 and k from 0 to 31, legal and illegal");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
